>>> src/pnse_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the petri net step engine
// no dependencies; used by every module of the block

package pnse_pkg;

	// default net size
	localparam int NUM_PLACES_DEF      = 16;
	localparam int NUM_TRANSITIONS_DEF = 16;
	localparam int TOKEN_BITS_DEF      = 16;

	// fixed request and result field widths
	localparam int REQ_W     = 3;
	localparam int TIDX_IN_W = 4;
	localparam int PIDX_IN_W = 4;
	localparam int TOKEN_IN_W = 16;
	localparam int TIU_W     = 5;

	// request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_ADD_IN  = 3'd0,
		REQ_ADD_OUT = 3'd1,
		REQ_SET     = 3'd2,
		REQ_STEP    = 3'd3,
		REQ_READ    = 3'd4
	} req_type_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIRE,
		ST_ARC,
		ST_DONE
	} state_t;

	// commands from the controller to the token counters
	typedef struct packed {
		logic set_en;
		logic fire_en;
	} mark_cmd_t;

endpackage

>>> src/pnse_arc_mem.sv
`timescale 1ns / 1ps
// arc memory: one row per transition holding its input and output place sets
// uses pnse_pkg for default sizes; one write and one registered read per cycle

module pnse_arc_mem #(
	parameter int ROWS  = pnse_pkg::NUM_TRANSITIONS_DEF,
	parameter int WIDTH = pnse_pkg::NUM_PLACES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    rd_en,
	input  logic [$clog2(ROWS)-1:0] rd_addr,
	output logic [WIDTH-1:0]        rd_in_mask,
	output logic [WIDTH-1:0]        rd_out_mask,
	input  logic                    wr_en,
	input  logic [$clog2(ROWS)-1:0] wr_addr,
	input  logic [WIDTH-1:0]        wr_in_mask,
	input  logic [WIDTH-1:0]        wr_out_mask
);

	logic [2*WIDTH-1:0] mem [ROWS];
	logic [ROWS-1:0]    row_valid_q;
	logic [2*WIDTH-1:0] rd_data_s1;
	logic               rd_valid_s1;

	// storage array, no reset
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_out_mask, wr_in_mask};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// row valid bits stand in for the all-empty reset contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_s1 <= row_valid_q[rd_addr];
			end
		end
	end

	// unwritten rows read as no arcs
	assign rd_in_mask  = rd_valid_s1 ? rd_data_s1[WIDTH-1:0] : '0;
	assign rd_out_mask = rd_valid_s1 ? rd_data_s1[2*WIDTH-1:WIDTH] : '0;

endmodule

>>> src/pnse_marking.sv
`timescale 1ns / 1ps
// token counters, one per place, with set, read and parallel firing update
// uses pnse_pkg for the command struct and field widths

module pnse_marking #(
	parameter int NUM_PLACES = pnse_pkg::NUM_PLACES_DEF,
	parameter int TOKEN_BITS = pnse_pkg::TOKEN_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pnse_pkg::mark_cmd_t              cmd,
	input  logic [$clog2(NUM_PLACES)-1:0]    addr,
	input  logic [pnse_pkg::TOKEN_IN_W-1:0]  set_value,
	input  logic [NUM_PLACES-1:0]            fire_in_mask,
	input  logic [NUM_PLACES-1:0]            fire_out_mask,
	output logic [TOKEN_BITS-1:0]            rd_data,
	output logic [NUM_PLACES-1:0]            nonzero
);

	localparam int PIDX_W = $clog2(NUM_PLACES);
	localparam int VW = (TOKEN_BITS > pnse_pkg::TOKEN_IN_W) ? TOKEN_BITS : pnse_pkg::TOKEN_IN_W;
	localparam logic [TOKEN_BITS-1:0] TOKEN_MAX = '1;

	logic [TOKEN_BITS-1:0] mark_q [NUM_PLACES];
	logic [TOKEN_BITS-1:0] fire_next [NUM_PLACES];
	logic [TOKEN_BITS-1:0] set_sat;
	logic [VW-1:0]         set_ext;

	// saturate the written count to the counter range
	always_comb begin
		set_ext = VW'(set_value);
		if (set_ext > VW'(TOKEN_MAX)) begin
			set_sat = TOKEN_MAX;
		end else begin
			set_sat = TOKEN_BITS'(set_ext);
		end
	end

	// firing: take one from each input place, then add one saturating
	always_comb begin
		logic [TOKEN_BITS-1:0] after_take;
		after_take = '0;
		for (int p = 0; p < NUM_PLACES; p++) begin
			after_take = mark_q[p];
			if (fire_in_mask[p] && (mark_q[p] != '0)) begin
				after_take = mark_q[p] - TOKEN_BITS'(1);
			end
			fire_next[p] = after_take;
			if (fire_out_mask[p] && (after_take != TOKEN_MAX)) begin
				fire_next[p] = after_take + TOKEN_BITS'(1);
			end
		end
	end

	// counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLACES; p++) begin
				mark_q[p] <= '0;
			end
		end else begin
			for (int p = 0; p < NUM_PLACES; p++) begin
				if (cmd.set_en && (addr == PIDX_W'(p))) begin
					mark_q[p] <= set_sat;
				end else if (cmd.fire_en) begin
					mark_q[p] <= fire_next[p];
				end
			end
		end
	end

	// read port and per-place nonzero flags for the enable test
	assign rd_data = mark_q[addr];

	always_comb begin
		for (int p = 0; p < NUM_PLACES; p++) begin
			nonzero[p] = (mark_q[p] != '0);
		end
	end

endmodule

>>> src/pnse_ctrl.sv
`timescale 1ns / 1ps
// request sequencer: decodes requests, runs the transition scan over the arc
// memory, drives arc read-modify-write and the token counters; uses pnse_pkg

module pnse_ctrl #(
	parameter int NUM_PLACES      = pnse_pkg::NUM_PLACES_DEF,
	parameter int NUM_TRANSITIONS = pnse_pkg::NUM_TRANSITIONS_DEF,
	parameter int TOKEN_BITS      = pnse_pkg::TOKEN_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config
	input  logic                                 cfg_wr_en,
	input  logic [pnse_pkg::TIU_W-1:0]           cfg_wr_data,
	// request side
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [pnse_pkg::REQ_W-1:0]           req_type,
	input  logic [pnse_pkg::TIDX_IN_W-1:0]       transition_index,
	input  logic [pnse_pkg::PIDX_IN_W-1:0]       place_index,
	// result side
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 fired,
	output logic [pnse_pkg::TIDX_IN_W-1:0]       fired_transition,
	output logic [pnse_pkg::TOKEN_IN_W-1:0]      token_count,
	// arc memory
	output logic                                 mem_rd_en,
	output logic [$clog2(NUM_TRANSITIONS)-1:0]   mem_rd_addr,
	input  logic [NUM_PLACES-1:0]                mem_rd_in_mask,
	input  logic [NUM_PLACES-1:0]                mem_rd_out_mask,
	output logic                                 mem_wr_en,
	output logic [$clog2(NUM_TRANSITIONS)-1:0]   mem_wr_addr,
	output logic [NUM_PLACES-1:0]                mem_wr_in_mask,
	output logic [NUM_PLACES-1:0]                mem_wr_out_mask,
	// token counters
	output pnse_pkg::mark_cmd_t                  mark_cmd,
	output logic [$clog2(NUM_PLACES)-1:0]        mark_addr,
	output logic [NUM_PLACES-1:0]                mark_fire_in,
	output logic [NUM_PLACES-1:0]                mark_fire_out,
	input  logic [TOKEN_BITS-1:0]                mark_rd_data,
	input  logic [NUM_PLACES-1:0]                mark_nonzero
);

	localparam int TIDX_W = $clog2(NUM_TRANSITIONS);
	localparam int PIDX_W = $clog2(NUM_PLACES);
	localparam int LIM_W  = $clog2(NUM_TRANSITIONS + 1);

	pnse_pkg::state_t    state_q, state_d;
	pnse_pkg::req_type_t req;

	logic [pnse_pkg::TIU_W-1:0] tiu_q;
	logic [LIM_W-1:0]           limit;
	logic                       accept, t_ok, p_ok, enabled, last_chk, out_free, out_load;

	logic                           is_out_q;
	logic [TIDX_W-1:0]              t_q;
	logic [NUM_PLACES-1:0]          pbit_q;
	logic [TIDX_W-1:0]              chk_q;
	logic [NUM_PLACES-1:0]          fire_in_q, fire_out_q;
	logic                           res_fired_q;
	logic [pnse_pkg::TIDX_IN_W-1:0] res_trans_q;
	logic [pnse_pkg::TOKEN_IN_W-1:0] res_count_q;
	logic                           out_valid_q;
	logic                           out_fired_q;
	logic [pnse_pkg::TIDX_IN_W-1:0] out_trans_q;
	logic [pnse_pkg::TOKEN_IN_W-1:0] out_count_q;

	// request decode
	always_comb begin
		req      = pnse_pkg::req_type_t'(req_type);
		accept   = in_valid && (state_q == pnse_pkg::ST_IDLE);
		t_ok     = 32'(transition_index) < 32'(NUM_TRANSITIONS);
		p_ok     = 32'(place_index) < 32'(NUM_PLACES);
		if (32'(tiu_q) > 32'(NUM_TRANSITIONS)) begin
			limit = LIM_W'(NUM_TRANSITIONS);
		end else begin
			limit = LIM_W'(tiu_q);
		end
		enabled  = (mem_rd_in_mask & ~mark_nonzero) == '0;
		last_chk = (LIM_W'(chk_q) + LIM_W'(1)) == limit;
		out_free = !out_valid_q || out_ready;
		out_load = (state_q == pnse_pkg::ST_DONE) && out_free;
	end

	// next state and memory / counter control
	always_comb begin
		state_d         = state_q;
		mem_rd_en       = 1'b0;
		mem_rd_addr     = chk_q + TIDX_W'(1);
		mem_wr_en       = 1'b0;
		mark_cmd.set_en  = 1'b0;
		mark_cmd.fire_en = 1'b0;
		case (state_q)
			pnse_pkg::ST_IDLE: begin
				if (accept) begin
					case (req)
						pnse_pkg::REQ_ADD_IN, pnse_pkg::REQ_ADD_OUT: begin
							if (t_ok && p_ok) begin
								mem_rd_en   = 1'b1;
								mem_rd_addr = TIDX_W'(transition_index);
								state_d     = pnse_pkg::ST_ARC;
							end else begin
								state_d = pnse_pkg::ST_DONE;
							end
						end
						pnse_pkg::REQ_SET: begin
							mark_cmd.set_en = p_ok;
							state_d         = pnse_pkg::ST_DONE;
						end
						pnse_pkg::REQ_STEP: begin
							if (limit != '0) begin
								mem_rd_en   = 1'b1;
								mem_rd_addr = '0;
								state_d     = pnse_pkg::ST_SCAN;
							end else begin
								state_d = pnse_pkg::ST_DONE;
							end
						end
						default: begin
							state_d = pnse_pkg::ST_DONE;
						end
					endcase
				end
			end
			pnse_pkg::ST_SCAN: begin
				if (enabled) begin
					state_d = pnse_pkg::ST_FIRE;
				end else if (last_chk) begin
					state_d = pnse_pkg::ST_DONE;
				end else begin
					mem_rd_en = 1'b1;
				end
			end
			pnse_pkg::ST_FIRE: begin
				mark_cmd.fire_en = 1'b1;
				state_d          = pnse_pkg::ST_DONE;
			end
			pnse_pkg::ST_ARC: begin
				mem_wr_en = 1'b1;
				state_d   = pnse_pkg::ST_DONE;
			end
			pnse_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = pnse_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pnse_pkg::ST_IDLE;
			end
		endcase
	end

	// arc row update: old row with the new place bit merged in
	assign mem_wr_addr     = t_q;
	assign mem_wr_in_mask  = mem_rd_in_mask | (is_out_q ? '0 : pbit_q);
	assign mem_wr_out_mask = mem_rd_out_mask | (is_out_q ? pbit_q : '0);

	assign mark_addr     = PIDX_W'(place_index);
	assign mark_fire_in  = fire_in_q;
	assign mark_fire_out = fire_out_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pnse_pkg::ST_IDLE;
			tiu_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				tiu_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and scan payload
	always_ff @(posedge clk) begin
		if (accept) begin
			is_out_q    <= (req == pnse_pkg::REQ_ADD_OUT);
			t_q         <= TIDX_W'(transition_index);
			pbit_q      <= NUM_PLACES'(1) << PIDX_W'(place_index);
			chk_q       <= '0;
			res_fired_q <= 1'b0;
			res_trans_q <= '0;
			if ((req == pnse_pkg::REQ_READ) && p_ok) begin
				res_count_q <= pnse_pkg::TOKEN_IN_W'(mark_rd_data);
			end else begin
				res_count_q <= '0;
			end
		end
		if (state_q == pnse_pkg::ST_SCAN) begin
			if (enabled) begin
				fire_in_q   <= mem_rd_in_mask;
				fire_out_q  <= mem_rd_out_mask;
				res_fired_q <= 1'b1;
				res_trans_q <= pnse_pkg::TIDX_IN_W'(chk_q);
			end else begin
				chk_q <= chk_q + TIDX_W'(1);
			end
		end
		if (out_load) begin
			out_fired_q <= res_fired_q;
			out_trans_q <= res_trans_q;
			out_count_q <= res_count_q;
		end
	end

	assign in_ready         = (state_q == pnse_pkg::ST_IDLE);
	assign out_valid        = out_valid_q;
	assign fired            = out_fired_q;
	assign fired_transition = out_trans_q;
	assign token_count      = out_count_q;

endmodule

>>> src/petri_net_step_engine.sv
`timescale 1ns / 1ps
// Petri net step engine, one request at a time, arcs held in a synchronous
// memory of one row per transition. A step reads one transition row per cycle
// through the arc memory read port and tests it against the nonzero flags of
// the token counters, over at most min(transitions_in_use, NUM_TRANSITIONS)
// rows. Arc adds are a read-modify-write of one row. A result waits in an
// output register, and the next request is taken once the previous result
// has moved there. The arc memory needs no clearing pass: rows that were
// never written read as empty through per-row valid bits.
// depends on pnse_pkg, pnse_arc_mem, pnse_marking and pnse_ctrl

module petri_net_step_engine #(
	parameter int NUM_PLACES      = pnse_pkg::NUM_PLACES_DEF,
	parameter int NUM_TRANSITIONS = pnse_pkg::NUM_TRANSITIONS_DEF,
	parameter int TOKEN_BITS      = pnse_pkg::TOKEN_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// transitions_in_use
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // transition_index[3:0], place_index[7:4], token_value[23:8]
	input  logic [2:0]  s_tuser,   // req_type[2:0]
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // fired[0], fired_transition[4:1], token_count[20:5], zero[23:21]
);

	localparam int TIDX_W = $clog2(NUM_TRANSITIONS);
	localparam int PIDX_W = $clog2(NUM_PLACES);

	logic                    mem_rd_en, mem_wr_en;
	logic [TIDX_W-1:0]       mem_rd_addr, mem_wr_addr;
	logic [NUM_PLACES-1:0]   mem_rd_in_mask, mem_rd_out_mask;
	logic [NUM_PLACES-1:0]   mem_wr_in_mask, mem_wr_out_mask;
	pnse_pkg::mark_cmd_t     mark_cmd;
	logic [PIDX_W-1:0]       mark_addr;
	logic [NUM_PLACES-1:0]   mark_fire_in, mark_fire_out, mark_nonzero;
	logic [TOKEN_BITS-1:0]   mark_rd_data;
	logic                    fired;
	logic [3:0]              fired_transition;
	logic [15:0]             token_count;

	// request sequencer
	pnse_ctrl #(
		.NUM_PLACES      (NUM_PLACES),
		.NUM_TRANSITIONS (NUM_TRANSITIONS),
		.TOKEN_BITS      (TOKEN_BITS)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (s_tvalid),
		.in_ready         (s_tready),
		.req_type         (s_tuser),
		.transition_index (s_tdata[3:0]),
		.place_index      (s_tdata[7:4]),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.fired            (fired),
		.fired_transition (fired_transition),
		.token_count      (token_count),
		.mem_rd_en        (mem_rd_en),
		.mem_rd_addr      (mem_rd_addr),
		.mem_rd_in_mask   (mem_rd_in_mask),
		.mem_rd_out_mask  (mem_rd_out_mask),
		.mem_wr_en        (mem_wr_en),
		.mem_wr_addr      (mem_wr_addr),
		.mem_wr_in_mask   (mem_wr_in_mask),
		.mem_wr_out_mask  (mem_wr_out_mask),
		.mark_cmd         (mark_cmd),
		.mark_addr        (mark_addr),
		.mark_fire_in     (mark_fire_in),
		.mark_fire_out    (mark_fire_out),
		.mark_rd_data     (mark_rd_data),
		.mark_nonzero     (mark_nonzero)
	);

	// arc sets per transition
	pnse_arc_mem #(
		.ROWS  (NUM_TRANSITIONS),
		.WIDTH (NUM_PLACES)
	) u_arc_mem (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_en       (mem_rd_en),
		.rd_addr     (mem_rd_addr),
		.rd_in_mask  (mem_rd_in_mask),
		.rd_out_mask (mem_rd_out_mask),
		.wr_en       (mem_wr_en),
		.wr_addr     (mem_wr_addr),
		.wr_in_mask  (mem_wr_in_mask),
		.wr_out_mask (mem_wr_out_mask)
	);

	// token counters
	pnse_marking #(
		.NUM_PLACES (NUM_PLACES),
		.TOKEN_BITS (TOKEN_BITS)
	) u_marking (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (mark_cmd),
		.addr          (mark_addr),
		.set_value     (s_tdata[23:8]),
		.fire_in_mask  (mark_fire_in),
		.fire_out_mask (mark_fire_out),
		.rd_data       (mark_rd_data),
		.nonzero       (mark_nonzero)
	);

	assign m_tdata = {3'b000, token_count, fired_transition, fired};

	// an accepted request holds the block until its result is formed
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in flight");

	// a step that fires nothing reports transition zero
	a_no_fire_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[4:1] == 4'd0)
		else $error("nonzero transition index without a firing");

	// a firing result carries no token count
	a_fire_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[20:5] == 16'd0)
		else $error("token count set on a firing result");

	// counters and arc memory are never written in the same cycle as a firing
	a_fire_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		mark_cmd.fire_en |-> !mark_cmd.set_en && !mem_wr_en)
		else $error("firing overlaps another state update");

endmodule
